// File: rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and codes of the WebSocket frame deframer
// Parse phases, opcodes, status codes and the result record that passes from
// the parser to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_HALT    = 3'd5;

  localparam logic [3:0] OP_TEXT  = 4'd1;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_BYTES = 3'd1;
  localparam logic [2:0] EXT64_BYTES = 3'd7;
  localparam logic [2:0] MASK_BYTES  = 3'd3;

  typedef struct packed {
    logic       vld;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [3:0] frame_opcode;
    logic       end_of_frame;
    logic [1:0] status;
    logic [3:0] reply_type;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/wsd_in_reg.sv
// ----------------------------------------------------------------------------
// wsd_in_reg: input register of the deframer
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output logic            byte_vld,
  output logic [7:0]      byte_data
);

  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       accept;

  assign in_stall  = vld_r && !take;
  assign accept    = in_valid && !in_stall;
  assign byte_vld  = vld_r;
  assign byte_data = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser: header parser and payload unmasker
// Advances the frame state by one byte per take and forms the result record.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  rx_byte,
  output wsd_pkg::res_t    res
);

  import wsd_pkg::*;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        fin_r, fin_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [3:0]  reply_r, reply_nxt;

  logic [63:0] len;
  logic        len_known;
  logic        finish;
  logic        emit;
  logic [7:0]  key_byte;
  logic [7:0]  v;

  always_comb begin
    unique case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign v    = rx_byte ^ key_byte;
  assign emit = (op_r == OP_TEXT) || (op_r == OP_BIN) || (op_r == OP_PING);

  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    fin_nxt   = fin_r;
    mask_nxt  = mask_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    pos_nxt   = pos_r;
    reply_nxt = reply_r;
    len       = rem_r;
    len_known = 1'b0;
    finish    = 1'b0;
    res       = '0;

    unique case (phase_r)
      PH_HDR0: begin
        fin_nxt   = rx_byte[7];
        op_nxt    = rx_byte[3:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        mask_nxt = rx_byte[7];
        rem_nxt  = '0;
        if (rx_byte[6:0] == LEN_EXT16) begin
          cnt_nxt   = EXT16_BYTES;
          phase_nxt = PH_EXT;
        end else if (rx_byte[6:0] == LEN_EXT64) begin
          cnt_nxt   = EXT64_BYTES;
          phase_nxt = PH_EXT;
        end else begin
          len       = {57'd0, rx_byte[6:0]};
          rem_nxt   = len;
          len_known = 1'b1;
        end
      end
      PH_EXT: begin
        len     = {rem_r[55:0], rx_byte};
        rem_nxt = len;
        if (cnt_r == 3'd0) begin
          len_known = 1'b1;
        end else begin
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], rx_byte};
        if (cnt_r == 3'd0) begin
          pos_nxt = 2'd0;
          if (rem_r == 64'd0) begin
            finish = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end else begin
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        pos_nxt = pos_r + 2'd1;
        rem_nxt = rem_r - 64'd1;
        if (rem_r == 64'd1) begin
          finish = 1'b1;
        end else if (emit) begin
          res.vld          = 1'b1;
          res.payload_byte = v;
          res.byte_valid   = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    if (len_known) begin
      key_nxt = '0;
      pos_nxt = 2'd0;
      if (mask_nxt) begin
        cnt_nxt   = MASK_BYTES;
        phase_nxt = PH_MASK;
      end else if (len != 64'd0) begin
        phase_nxt        = PH_HALT;
        res.vld          = 1'b1;
        res.end_of_frame = 1'b1;
        res.status       = ST_ERROR;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      res.vld          = 1'b1;
      res.end_of_frame = 1'b1;
      if (phase_r == PH_PAYLOAD && emit) begin
        res.byte_valid   = 1'b1;
        res.payload_byte = v;
      end
      unique case (op_r)
        OP_CLOSE: begin
          res.status = ST_CLOSED;
          phase_nxt  = PH_HALT;
        end
        OP_PING, OP_PONG: begin
          res.status = ST_OK;
          phase_nxt  = PH_HDR0;
        end
        OP_TEXT, OP_BIN: begin
          if (fin_r) begin
            reply_nxt  = op_r;
            res.status = ST_OK;
            phase_nxt  = PH_HDR0;
          end else begin
            res.status = ST_ERROR;
            phase_nxt  = PH_HALT;
          end
        end
        default: begin
          res.status = ST_ERROR;
          phase_nxt  = PH_HALT;
        end
      endcase
    end

    res.frame_opcode = op_r;
    res.reply_type   = reply_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      op_r    <= '0;
      fin_r   <= 1'b0;
      mask_r  <= 1'b0;
      rem_r   <= '0;
      cnt_r   <= '0;
      key_r   <= '0;
      pos_r   <= '0;
      reply_r <= OP_TEXT;
    end else if (take) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      fin_r   <= fin_nxt;
      mask_r  <= mask_nxt;
      rem_r   <= rem_nxt;
      cnt_r   <= cnt_nxt;
      key_r   <= key_nxt;
      pos_r   <= pos_nxt;
      reply_r <= reply_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side WebSocket frame parser
// Parses frame headers, unmasks payload bytes and reports frame-end status.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_rx_byte
//   out_     output     out_valid/out_stall  payload_byte, byte_valid,
//                                            frame_opcode, end_of_frame,
//                                            status, reply_type
//
// One byte per cycle unless the output stalls: input register, one pass of
// parser logic, result register. A byte's result is registered in the result
// register; the 64-bit length decrement and compare set the path. Reset is
// synchronous and clears all control state. A stalled result holds the
// parser; one further byte is still taken into the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_payload_byte,
  output logic            out_byte_valid,
  output logic [3:0]      out_frame_opcode,
  output logic            out_end_of_frame,
  output logic [1:0]      out_status,
  output logic [3:0]      out_reply_type
);

  import wsd_pkg::*;

  logic       byte_vld;
  logic [7:0] byte_data;
  logic       take;
  res_t       res;
  res_t       out_r;
  logic       out_vld_r, out_vld_nxt;

  assign take = byte_vld && (!out_vld_r || !out_stall);

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .byte_vld   (byte_vld),
    .byte_data  (byte_data)
  );

  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (byte_data),
    .res     (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = res.vld;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.vld) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_valid   = out_r.byte_valid;
  assign out_frame_opcode = out_r.frame_opcode;
  assign out_end_of_frame = out_r.end_of_frame;
  assign out_status       = out_r.status;
  assign out_reply_type   = out_r.reply_type;

endmodule

`default_nettype wire

// File: test/websocket_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb: self-checking bench for the frame deframer
// Streams WebSocket frames byte by byte: a directed set of header forms, then
// random text, binary, ping and pong frames with short, 16-bit and 64-bit
// lengths and random mask keys, closed by one randomly chosen terminating case
// (close, fragment, unknown opcode, unmasked payload or an endless frame).
// A scoreboard predicts every result from the accepted bytes and checks each
// output transfer in order. Both sides idle in random bursts before QUIET_FROM.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int FORM_SHORT  = 0;
  localparam int FORM_EXT16  = 1;
  localparam int FORM_EXT64  = 2;
  localparam int BYTE_TARGET = 550;
  localparam int QUIET_FROM  = 420;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic [3:0] frame_opcode;
    logic       end_of_frame;
    logic [1:0] status;
    logic [3:0] reply_type;
  } frame_result_t;

  class deframer_scoreboard;
    logic [2:0]      phase;
    logic [3:0]      op;
    logic            fin;
    logic            masked;
    logic [63:0]     remaining;
    logic [2:0]      hdr_left;
    logic [31:0]     key;
    logic [1:0]      key_pos;
    logic [3:0]      reply_op;
    frame_result_t   pending[$];
    int              errors;
    int              checked;

    function new();
      phase     = PH_HDR0;
      op        = '0;
      fin       = 1'b0;
      masked    = 1'b0;
      remaining = '0;
      hdr_left  = '0;
      key       = '0;
      key_pos   = '0;
      reply_op  = OP_TEXT;
      errors    = 0;
      checked   = 0;
    endfunction

    function void push(logic [7:0] data, logic valid, logic eof, logic [1:0] st);
      frame_result_t r;
      r.payload_byte = valid ? data : 8'h00;
      r.byte_valid   = valid;
      r.frame_opcode = op;
      r.end_of_frame = eof;
      r.status       = st;
      r.reply_type   = reply_op;
      pending.push_back(r);
    endfunction

    function void close_frame(logic [7:0] data, logic valid);
      logic [1:0] st;
      case (op)
        OP_CLOSE: begin
          st    = ST_CLOSED;
          phase = PH_HALT;
        end
        OP_PING, OP_PONG: begin
          st    = ST_OK;
          phase = PH_HDR0;
        end
        OP_TEXT, OP_BIN: begin
          if (fin) begin
            reply_op = op;
            st       = ST_OK;
            phase    = PH_HDR0;
          end else begin
            st    = ST_ERROR;
            phase = PH_HALT;
          end
        end
        default: begin
          st    = ST_ERROR;
          phase = PH_HALT;
        end
      endcase
      push(data, valid, 1'b1, st);
    endfunction

    function void length_done();
      key     = '0;
      key_pos = '0;
      if (masked) begin
        hdr_left = MASK_BYTES;
        phase    = PH_MASK;
      end else if (remaining != 0) begin
        phase = PH_HALT;
        push(8'h00, 1'b0, 1'b1, ST_ERROR);
      end else begin
        close_frame(8'h00, 1'b0);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [6:0] len7;
      logic [7:0] v;
      int         shift;
      case (phase)
        PH_HDR0: begin
          fin   = b[7];
          op    = b[3:0];
          phase = PH_HDR1;
        end
        PH_HDR1: begin
          masked    = b[7];
          len7      = b[6:0];
          remaining = '0;
          if (len7 == LEN_EXT16) begin
            hdr_left = EXT16_BYTES;
            phase    = PH_EXT;
          end else if (len7 == LEN_EXT64) begin
            hdr_left = EXT64_BYTES;
            phase    = PH_EXT;
          end else begin
            remaining = {57'd0, len7};
            length_done();
          end
        end
        PH_EXT: begin
          remaining = {remaining[55:0], b};
          if (hdr_left == 0) length_done();
          else hdr_left = hdr_left - 3'd1;
        end
        PH_MASK: begin
          key = {key[23:0], b};
          if (hdr_left == 0) begin
            key_pos = '0;
            if (remaining == 0) close_frame(8'h00, 1'b0);
            else phase = PH_PAYLOAD;
          end else begin
            hdr_left = hdr_left - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          shift     = 8 * (3 - int'(key_pos));
          v         = b ^ key[shift +: 8];
          key_pos   = key_pos + 2'd1;
          remaining = remaining - 64'd1;
          if (remaining == 0) begin
            close_frame(v, op == OP_TEXT || op == OP_BIN || op == OP_PING);
          end else if (op == OP_TEXT || op == OP_BIN || op == OP_PING) begin
            push(v, 1'b1, 1'b0, ST_OK);
          end
        end
        default: phase = PH_HALT;
      endcase
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result byte=%02h valid=%0d op=%0d eof=%0d status=%0d reply=%0d",
                 $time, got.payload_byte, got.byte_valid, got.frame_opcode,
                 got.end_of_frame, got.status, got.reply_type);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: mismatch expected byte=%02h valid=%0d op=%0d eof=%0d status=%0d reply=%0d",
                 $time, want.payload_byte, want.byte_valid, want.frame_opcode,
                 want.end_of_frame, want.status, want.reply_type);
        $display("%0t:          actual   byte=%02h valid=%0d op=%0d eof=%0d status=%0d reply=%0d",
                 $time, got.payload_byte, got.byte_valid, got.frame_opcode,
                 got.end_of_frame, got.status, got.reply_type);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_byte_valid;
  logic [3:0] out_frame_opcode;
  logic       out_end_of_frame;
  logic [1:0] out_status;
  logic [3:0] out_reply_type;

  deframer_scoreboard sb;
  bit    send_idle = 1'b1;
  bit    recv_idle = 1'b1;
  int    bytes_sent = 0;
  int    frames_sent = 0;
  int    stall_left = 0;
  int    cycles = 0;
  string end_case = "none";

  websocket_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_byte (out_payload_byte),
    .out_byte_valid   (out_byte_valid),
    .out_frame_opcode (out_frame_opcode),
    .out_end_of_frame (out_end_of_frame),
    .out_status       (out_status),
    .out_reply_type   (out_reply_type)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    frame_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.payload_byte = out_payload_byte;
      got.byte_valid   = out_byte_valid;
      got.frame_opcode = out_frame_opcode;
      got.end_of_frame = out_end_of_frame;
      got.status       = out_status;
      got.reply_type   = out_reply_type;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (send_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic drain_expected();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] opc, input logic masked,
                            input int form, input logic [63:0] len,
                            input logic [31:0] key, input int body);
    logic [2:0] rsv;
    logic [6:0] len7;
    rsv  = 3'($urandom);
    len7 = (form == FORM_EXT16) ? LEN_EXT16 :
           (form == FORM_EXT64) ? LEN_EXT64 : len[6:0];
    send_byte({fin, rsv, opc});
    send_byte({masked, len7});
    if (form == FORM_EXT16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == FORM_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    repeat (body) send_byte(8'($urandom));
    frames_sent++;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_frame();
    logic [3:0]  opc;
    logic        masked;
    int          form;
    logic [63:0] len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: opc = OP_TEXT;
      4, 5, 6:    opc = OP_BIN;
      7:          opc = OP_PING;
      8:          opc = OP_PONG;
      default:    opc = OP_BIN;
    endcase
    case ($urandom_range(0, 9))
      7, 8:    form = FORM_EXT16;
      9:       form = FORM_EXT64;
      default: form = FORM_SHORT;
    endcase
    if (form == FORM_EXT16)
      len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(126, 300))
                                        : 64'($urandom_range(0, 40));
    else if (form == FORM_EXT64)
      len = 64'($urandom_range(0, 24));
    else
      len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(13, 125))
                                        : 64'($urandom_range(0, 12));
    masked = 1'b1;
    if ($urandom_range(0, 11) == 0) begin
      masked = 1'b0;
      len    = '0;
    end
    send_frame(1'b1, opc, masked, form, len, pick_key(), int'(len));
  endtask

  task automatic send_final_frame();
    logic [3:0]  opc;
    logic [63:0] len;
    int          n;
    case ($urandom_range(0, 4))
      0: begin
        end_case = "endless frame";
        len      = {8'($urandom_range(1, 255)), 56'({$urandom, $urandom})};
        send_frame(1'b1, OP_BIN, 1'b1, FORM_EXT64, len, pick_key(), 20);
      end
      1: begin
        end_case = "close";
        n        = $urandom_range(0, 6);
        send_frame(1'b1, OP_CLOSE, 1'b1, FORM_SHORT, 64'(n), pick_key(), n);
      end
      2: begin
        end_case = "fragment";
        n        = $urandom_range(0, 6);
        opc      = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
        send_frame(1'b0, opc, 1'b1, FORM_SHORT, 64'(n), pick_key(), n);
      end
      3: begin
        end_case = "unknown opcode";
        do opc = 4'($urandom);
        while (opc == OP_TEXT || opc == OP_BIN || opc == OP_CLOSE ||
               opc == OP_PING || opc == OP_PONG);
        n = $urandom_range(0, 6);
        send_frame(1'b1, opc, 1'b1, FORM_SHORT, 64'(n), pick_key(), n);
      end
      default: begin
        end_case = "unmasked payload";
        n        = $urandom_range(1, 10);
        send_frame(1'b1, OP_TEXT, 1'b0, FORM_EXT16, 64'(n), '0, n);
      end
    endcase
    repeat ($urandom_range(3, 8)) send_byte(8'($urandom));
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(1'b1, OP_BIN, 1'b0, FORM_SHORT, 64'd0, 32'h0, 0);
    send_frame(1'b1, OP_PONG, 1'b1, FORM_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
    send_frame(1'b1, OP_PING, 1'b1, FORM_SHORT, 64'd1, 32'h0000_0000, 1);
    send_frame(1'b1, OP_TEXT, 1'b1, FORM_EXT16, 64'd3, 32'hA5C3_5A3C, 3);

    while (bytes_sent < BYTE_TARGET) begin
      if (!paused && bytes_sent > BYTE_TARGET / 2) begin
        paused = 1'b1;
        drain_expected();
      end
      if (bytes_sent > QUIET_FROM) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      send_random_frame();
    end
    send_final_frame();

    drain_expected();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes in %0d frames, last case: %s", bytes_sent, frames_sent, end_case);
    $display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
